>>> hw/rtl/tcrrq_pkg.sv
// ----------------------------------------------------------------------------
// tcrrq_pkg: shared types and constants of the round-robin band scheduler
// Sizes of the band queues, status codes, per-band descriptor layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrrq_pkg;

    // sizing
    localparam int MAX_BANDS   = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;

    localparam int BIDX_W  = $clog2(MAX_BANDS);          // band index into storage
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);        // queue slot pointer
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);    // queue fill count
    localparam int SADDR_W = BIDX_W + PTR_W;             // handle store address
    localparam int SDEPTH  = MAX_BANDS * QUEUE_DEPTH;

    // fixed field widths
    localparam int BAND_W = 4;
    localparam int NB_W   = 5;
    localparam int MAP_W  = 64;
    localparam int OCC_W  = 7;
    localparam int HOUT_W = 16;
    localparam int STAT_W = 3;

    // register indexes
    localparam logic REG_TOS_MAP   = 1'b0;
    localparam logic REG_NUM_BANDS = 1'b1;

    localparam logic [MAP_W-1:0] TOS_MAP_RESET   = 64'h1111_1111_0021_2221;
    localparam logic [NB_W-1:0]  NUM_BANDS_RESET = 5'd3;

    // request kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ENQ   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BAD   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DEQ   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

    // per-band queue descriptor
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } t_meta;

    // classification and scan answer
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic              bad;
        logic              empty;
    } t_pick;

    // circular pointer advance
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcrrq_ram.sv
// ----------------------------------------------------------------------------
// tcrrq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcrrq_pick.sv
// ----------------------------------------------------------------------------
// tcrrq_pick: band classification and round-robin scan
// Picks the target band of an enqueue, or the band to serve for a dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrrq_pick
    import tcrrq_pkg::*;
(
    input  wire logic                    i_kind,
    input  wire logic [7:0]              i_tos_byte,
    input  wire logic                    i_tos_present,
    input  wire logic                    i_filter_matched,
    input  wire logic signed [7:0]       i_filter_band,
    input  wire logic [MAP_W-1:0]        i_tos_map,
    input  wire logic [NB_W-1:0]         i_num_bands,
    input  wire logic [MAX_BANDS-1:0]    i_nonempty,
    input  wire logic [BAND_W-1:0]       i_last_served,
    output t_pick                        o_pick
);

    logic [NB_W-1:0]      nb;
    logic [3:0]           map_idx;
    logic [BAND_W-1:0]    entry0;
    logic [BAND_W-1:0]    entry_tos;
    logic                 fb_in_range;
    logic [BAND_W-1:0]    enq_band;
    logic [NB_W-1:0]      start;
    logic [MAX_BANDS-1:0] avail;
    logic [MAX_BANDS-1:0] upper;
    logic [BAND_W-1:0]    up_idx;
    logic [BAND_W-1:0]    all_idx;

    // lowest set bit of a band vector
    function automatic logic [BAND_W-1:0] lowest_set(input logic [MAX_BANDS-1:0] v);
        logic [BAND_W-1:0] r;
        r = '0;
        for (int i = MAX_BANDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BAND_W'(i);
            end
        end
        return r;
    endfunction

    // bands in use, clamped to the storage
    assign nb = (i_num_bands > NB_W'(MAX_BANDS)) ? NB_W'(MAX_BANDS) : i_num_bands;

    // map lookup
    assign map_idx   = i_tos_byte[4:1];
    assign entry0    = i_tos_map[BAND_W-1:0];
    assign entry_tos = i_tos_map[{map_idx, 2'b00} +: BAND_W];

    // filter answer is usable only when non-negative and below the band count
    assign fb_in_range = !i_filter_band[7] &&
                         ($unsigned(i_filter_band) < {3'b000, nb});

    // enqueue band choice
    always_comb begin
        enq_band = entry0;
        if (i_filter_matched) begin
            if (fb_in_range) begin
                enq_band = i_filter_band[BAND_W-1:0];
            end
        end else if (i_tos_present) begin
            enq_band = entry_tos;
        end
    end

    // scan start after the last served band, wrapping at the band count
    always_comb begin
        start = NB_W'(i_last_served) + 1'b1;
        if (start >= nb) begin
            start = '0;
        end
    end

    // candidate bands: non-empty and in use; upper part from the start on
    always_comb begin
        for (int i = 0; i < MAX_BANDS; i++) begin
            avail[i] = i_nonempty[i] && (NB_W'(i) < nb);
            upper[i] = avail[i] && (NB_W'(i) >= start);
        end
    end

    assign up_idx  = lowest_set(upper);
    assign all_idx = lowest_set(avail);

    // answer
    always_comb begin
        o_pick = '0;
        if (i_kind == KIND_ENQ) begin
            o_pick.band = enq_band;
            o_pick.bad  = ({1'b0, enq_band} >= nb);
        end else begin
            o_pick.empty = (avail == '0);
            if (upper != '0) begin
                o_pick.band = up_idx;
            end else if (avail != '0) begin
                o_pick.band = all_idx;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tos_classified_round_robin_queues_unit.sv
// ----------------------------------------------------------------------------
// tos_classified_round_robin_queues_unit: ToS-classified round-robin queues
// Per-band packet handle queues with filter/ToS classification and
// round-robin service, state held in a descriptor RAM and a handle RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (tuser = kind: 0 enqueue, 1 dequeue).
//   Each request yields exactly one result on the m_ stream, tuser = status.
//   Enqueue, drop and empty requests: the accept cycle reads the band
//   descriptor RAM, then the descriptor update step updates it and loads the result.
//   A successful dequeue adds a handle step: the handle RAM read follows the
//   descriptor read, since the head pointer lives in the descriptor RAM.
//   One request is in work at a time; o_s_tready is high whenever no
//   request is in work, also while a finished result waits on the m_ side.
//   When the receiver stalls, the result register holds and the next
//   request waits in its descriptor update step until the result register
//   frees up.
//   Reset (synchronous, active low) empties all bands, clears the last
//   served band and loads the register defaults; handle RAM is not cleared.
//   Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_classified_round_robin_queues_unit
    import tcrrq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: tos_byte[7:0], tos_present[8], filter_matched[9],
    //        filter_band[17:10], packet_handle[33:18], zero pad[39:34]
    input  wire logic [39:0]       i_s_tdata,
    // tuser: kind[0]
    input  wire logic [0:0]        i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // tdata: band[3:0], handle_out[19:4], band_occupancy[26:20], zero pad[31:27]
    output logic      [31:0]       o_m_tdata,
    // tuser: status[2:0]
    output logic      [2:0]        o_m_tuser,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [MAP_W-1:0]  i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_META = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [MAP_W-1:0]        r_tos_map;
    logic [NB_W-1:0]         r_num_bands;
    logic [MAX_BANDS-1:0]    r_meta_vld, n_meta_vld;
    logic [MAX_BANDS-1:0]    r_nonempty, n_nonempty;
    logic [BAND_W-1:0]       r_last, n_last;

    // request context
    logic                    r_kind;
    logic [BAND_W-1:0]       r_band;
    logic                    r_bad;
    logic                    r_empty;
    logic [HANDLE_BITS-1:0]  r_handle;
    logic                    r_rd_vld;
    logic [CNT_W-1:0]        r_occ_pend, n_occ_pend;

    // result register
    logic                    r_out_valid, n_out_valid;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [BAND_W-1:0]       r_out_band, n_out_band;
    logic [HOUT_W-1:0]       r_out_handle, n_out_handle;
    logic [OCC_W-1:0]        r_out_occ, n_out_occ;

    logic                    s_accept;
    logic                    go;
    logic signed [7:0]       filter_band;
    t_pick                   pick;
    logic [BIDX_W-1:0]       pick_idx;
    logic [BIDX_W-1:0]       cur_idx;

    logic                    meta_we;
    t_meta                   meta_wdata;
    logic [$bits(t_meta)-1:0] meta_rdata_raw;
    t_meta                   meta_rd;
    logic                    store_we;
    logic                    store_re;
    logic [SADDR_W-1:0]      store_waddr;
    logic [SADDR_W-1:0]      store_raddr;
    logic [HANDLE_BITS-1:0]  store_rdata;

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign go          = !r_out_valid || i_m_tready;
    assign filter_band = $signed(i_s_tdata[17:10]);

    // classification and scan
    tcrrq_pick u_pick (
        .i_kind           (i_s_tuser[0]),
        .i_tos_byte       (i_s_tdata[7:0]),
        .i_tos_present    (i_s_tdata[8]),
        .i_filter_matched (i_s_tdata[9]),
        .i_filter_band    (filter_band),
        .i_tos_map        (r_tos_map),
        .i_num_bands      (r_num_bands),
        .i_nonempty       (r_nonempty),
        .i_last_served    (r_last),
        .o_pick           (pick)
    );

    assign pick_idx = pick.band[BIDX_W-1:0];
    assign cur_idx  = r_band[BIDX_W-1:0];

    // band descriptor RAM
    tcrrq_ram #(
        .WIDTH ($bits(t_meta)),
        .DEPTH (MAX_BANDS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (cur_idx),
        .i_wdata (meta_wdata),
        .i_re    (s_accept),
        .i_raddr (pick_idx),
        .o_rdata (meta_rdata_raw)
    );

    // never written descriptors read as an empty band
    assign meta_rd = r_rd_vld ? t_meta'(meta_rdata_raw) : '0;

    // handle store RAM
    tcrrq_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (SDEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_handle),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    assign store_waddr = {cur_idx, meta_rd.tail};
    assign store_raddr = {cur_idx, meta_rd.head};

    // sequencer: descriptor update and result load
    always_comb begin
        n_state      = r_state;
        n_meta_vld   = r_meta_vld;
        n_nonempty   = r_nonempty;
        n_last       = r_last;
        n_occ_pend   = r_occ_pend;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_status     = r_status;
        n_out_band   = r_out_band;
        n_out_handle = r_out_handle;
        n_out_occ    = r_out_occ;
        meta_we      = 1'b0;
        meta_wdata   = meta_rd;
        store_we     = 1'b0;
        store_re     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                if (go) begin
                    n_state = S_IDLE;
                    if (r_kind == KIND_ENQ) begin
                        n_out_valid  = 1'b1;
                        n_out_band   = r_band;
                        n_out_handle = '0;
                        if (r_bad) begin
                            n_status  = STAT_BAD;
                            n_out_occ = '0;
                        end else if (meta_rd.count >= CNT_W'(QUEUE_DEPTH)) begin
                            n_status  = STAT_FULL;
                            n_out_occ = OCC_W'(meta_rd.count);
                        end else begin
                            store_we            = 1'b1;
                            meta_we             = 1'b1;
                            meta_wdata.tail     = ptr_next(meta_rd.tail);
                            meta_wdata.count    = meta_rd.count + 1'b1;
                            n_meta_vld[cur_idx] = 1'b1;
                            n_nonempty[cur_idx] = 1'b1;
                            n_status            = STAT_ENQ;
                            n_out_occ           = OCC_W'(meta_rd.count + 1'b1);
                        end
                    end else if (r_empty) begin
                        n_out_valid  = 1'b1;
                        n_status     = STAT_EMPTY;
                        n_out_band   = '0;
                        n_out_handle = '0;
                        n_out_occ    = '0;
                    end else begin
                        // pop: advance head and issue the handle read
                        store_re            = 1'b1;
                        meta_we             = 1'b1;
                        meta_wdata.head     = ptr_next(meta_rd.head);
                        meta_wdata.count    = meta_rd.count - 1'b1;
                        n_meta_vld[cur_idx] = 1'b1;
                        n_nonempty[cur_idx] = (meta_rd.count != CNT_W'(1));
                        n_last              = r_band;
                        n_occ_pend          = meta_rd.count - 1'b1;
                        n_state             = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (go) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_status     = STAT_DEQ;
                    n_out_band   = r_band;
                    n_out_handle = HOUT_W'(store_rdata);
                    n_out_occ    = OCC_W'(r_occ_pend);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_meta_vld  <= '0;
            r_nonempty  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_meta_vld  <= n_meta_vld;
            r_nonempty  <= n_nonempty;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tos_map   <= TOS_MAP_RESET;
            r_num_bands <= NUM_BANDS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TOS_MAP:   r_tos_map   <= i_cfg_data;
                REG_NUM_BANDS: r_num_bands <= i_cfg_data[NB_W-1:0];
                default:       r_num_bands <= r_num_bands;
            endcase
        end
    end

    // request context and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind   <= i_s_tuser[0];
            r_band   <= pick.band;
            r_bad    <= pick.bad;
            r_empty  <= pick.empty;
            r_handle <= i_s_tdata[18 +: HANDLE_BITS];
            r_rd_vld <= r_meta_vld[pick_idx];
        end
        r_occ_pend   <= n_occ_pend;
        r_status     <= n_status;
        r_out_band   <= n_out_band;
        r_out_handle <= n_out_handle;
        r_out_occ    <= n_out_occ;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {5'b00000, r_out_occ, r_out_handle, r_out_band};

endmodule

`default_nettype wire

>>> hw/rtl/tcrrq_checker.sv
// ----------------------------------------------------------------------------
// tcrrq_checker: port-level assertions of the round-robin band scheduler
// Watches the request and result streams of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrrq_checker
    import tcrrq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic [2:0]  o_m_tuser
);

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped under stall");

    // one request in work at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // status stays within its codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == STAT_ENQ || o_m_tuser == STAT_FULL ||
                        o_m_tuser == STAT_BAD || o_m_tuser == STAT_DEQ ||
                        o_m_tuser == STAT_EMPTY))
        else $error("unknown status code");

    // only a dequeue carries a handle
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != STAT_DEQ) |-> (o_m_tdata[19:4] == '0))
        else $error("handle on a result that is not a dequeue");

endmodule

bind tos_classified_round_robin_queues_unit tcrrq_checker u_tcrrq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
